@@ hw/rtl/least_connections_server_selector_unit_assert.svh @@
// Assertion macros for the least-connections server selector.
// Included by the top level; needs nothing else.
`ifndef LEAST_CONNECTIONS_SERVER_SELECTOR_UNIT_ASSERT_SVH
`define LEAST_CONNECTIONS_SERVER_SELECTOR_UNIT_ASSERT_SVH

// cond in the same cycle
`define LCSS_ASSERT_SAME(lbl, clk, rst_n, ante, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cond)) \
        else $error(msg);

// cond in the next cycle
`define LCSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cond)) \
        else $error(msg);

`endif

@@ hw/rtl/lcss_pkg.sv @@
// Shared types and constants for the least-connections server selector.
// No dependencies.
`default_nettype none
package lcss_pkg;

    localparam int CountW = 20;
    localparam int TotalW = 24;
    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
    localparam logic [TotalW-1:0] TOTAL_MAX = {TotalW{1'b1}};

    typedef enum logic [2:0] {
        ACT_REGISTER = 3'd0,
        ACT_USER_ADD = 3'd1,
        ACT_USER_DEL = 3'd2,
        ACT_REMOVE   = 3'd3,
        ACT_REQUEST  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_SERVER  = 3'd1,
        STAT_ALL_FULL   = 3'd2,
        STAT_UNKNOWN    = 3'd3,
        STAT_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC
    } t_state;

    // one table entry, also the layout of the captured input item
    typedef struct packed {
        logic [CountW-1:0] count;
        logic [CountW-1:0] capacity;
        logic [15:0]       port;
        logic [31:0]       address;
        logic [15:0]       handle;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic beat;
        logic vbit;
    } t_scan_ctl;

    typedef struct packed {
        logic   found;
        logic   any;
        logic   best_found;
        logic   free_found;
        t_entry match;
        t_entry best;
    } t_scan_res;

endpackage
`default_nettype wire

@@ hw/rtl/lcss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module lcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/lcss_scan.sv @@
// Scan accumulator: takes one table entry per cycle while beat is set and keeps the handle
// match, the lowest free slot and the least-loaded open server. Uses lcss_pkg.
`default_nettype none
module lcss_scan #(
    parameter int NUM_SERVERS = 16,
    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
    input  wire logic               i_clk,
    input  wire lcss_pkg::t_scan_ctl i_ctl,
    input  wire logic [IW-1:0]      i_idx,
    input  wire lcss_pkg::t_entry   i_entry,
    input  wire logic [15:0]        i_handle,
    output lcss_pkg::t_scan_res     o_res,
    output logic      [IW-1:0]      o_match_idx,
    output logic      [IW-1:0]      o_free_idx
);
    import lcss_pkg::*;

    t_scan_res   r_res;
    logic [IW-1:0] r_match_idx;
    logic [IW-1:0] r_free_idx;
    logic        open_slot;
    logic        better;

    always_comb begin
        open_slot = i_entry.count < i_entry.capacity;
        better = !r_res.best_found || (i_entry.count < r_res.best.count) ||
                 ((i_entry.count == r_res.best.count) &&
                  (i_entry.handle < r_res.best.handle));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_res.found      <= 1'b0;
            r_res.any        <= 1'b0;
            r_res.best_found <= 1'b0;
            r_res.free_found <= 1'b0;
        end else if (i_ctl.beat) begin
            if (i_ctl.vbit) begin
                r_res.any <= 1'b1;
                if (!r_res.found && (i_entry.handle == i_handle)) begin
                    r_res.found <= 1'b1;
                    r_res.match <= i_entry;
                    r_match_idx <= i_idx;
                end
                if (open_slot && better) begin
                    r_res.best_found <= 1'b1;
                    r_res.best       <= i_entry;
                end
            end else if (!r_res.free_found) begin
                r_res.free_found <= 1'b1;
                r_free_idx       <= i_idx;
            end
        end
    end

    assign o_res       = r_res;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;

endmodule
`default_nettype wire

@@ hw/rtl/least_connections_server_selector_unit.sv @@
// Least-connections server selector: entry table in one RAM, scanned per item.
// Each item runs S_SCAN (all table entries read through the single registered
// RAM read port into lcss_scan), S_DRAIN (last read word scanned) and S_EXEC (update,
// held while the last result still waits for tready); a new item is taken only in S_IDLE.
// Reset clears valid bits, the online total and control; RAM contents are left as is.
// Uses lcss_pkg, lcss_ram, lcss_scan and the assertion macro header.
`default_nettype none
module least_connections_server_selector_unit #(
    parameter int NUM_SERVERS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata: server_handle, ip_address, port_number, capacity, initial_count
    input  wire logic [103:0] i_s_axis_tdata,
    // tuser: action
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata: chosen_handle, chosen_address, chosen_port, total_online
    output logic      [87:0]  o_m_axis_tdata,
    // tuser: status
    output logic      [2:0]   o_m_axis_tuser
);
    import lcss_pkg::*;

    `include "least_connections_server_selector_unit_assert.svh"

    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SERVERS - 1);

    t_state  r_state, n_state;
    t_action r_action;
    t_entry  r_item;
    logic [IW-1:0] r_addr;
    logic [IW-1:0] r_rd_idx;
    logic          r_beat;
    logic [NUM_SERVERS-1:0] r_valid;
    logic [TotalW-1:0] r_total, n_total;

    logic            r_out_valid;
    t_status         r_out_status;
    logic [15:0]     r_out_handle;
    logic [31:0]     r_out_addr;
    logic [15:0]     r_out_port;

    logic          accept;
    logic          exec_fire;
    logic          scan_clear;
    t_scan_ctl     scan_ctl;
    t_scan_res     res;
    logic [IW-1:0] match_idx;
    logic [IW-1:0] free_idx;
    t_entry        rd_entry;
    logic [$bits(t_entry)-1:0] rd_word;

    logic          we;
    logic [IW-1:0] waddr;
    t_entry        wentry;
    logic          set_valid;
    logic          clr_valid;
    t_status       n_status;
    logic          chosen;
    logic [CountW-1:0] add_val;
    logic [CountW-1:0] sub_val;
    logic [TotalW:0]   sum;

    assign accept = (r_state == S_IDLE) && i_s_axis_tvalid && i_rst_n;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_SCAN;
            S_SCAN:  if (r_addr == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN: n_state = S_EXEC;
            S_EXEC:  if (!r_out_valid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        scan_clear      = 1'b0;
        exec_fire       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = i_rst_n;
                scan_clear      = i_s_axis_tvalid && i_rst_n;
            end
            S_EXEC:  exec_fire = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_beat  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_beat  <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_s_axis_tuser);
            r_item   <= {i_s_axis_tdata[103:84], i_s_axis_tdata[83:64],
                         i_s_axis_tdata[63:48], i_s_axis_tdata[47:16],
                         i_s_axis_tdata[15:0]};
        end
        if (accept) begin
            r_addr <= '0;
        end else if (r_state == S_SCAN) begin
            r_addr <= r_addr + IW'(1);
        end
        r_rd_idx <= r_addr;
    end

    lcss_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_SERVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (r_addr),
        .o_rdata (rd_word)
    );

    assign rd_entry = t_entry'(rd_word);

    assign scan_ctl.clear = scan_clear;
    assign scan_ctl.beat  = r_beat;
    assign scan_ctl.vbit  = r_valid[r_rd_idx];

    lcss_scan #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_ctl       (scan_ctl),
        .i_idx       (r_rd_idx),
        .i_entry     (rd_entry),
        .i_handle    (r_item.handle),
        .o_res       (res),
        .o_match_idx (match_idx),
        .o_free_idx  (free_idx)
    );

    // update decision
    always_comb begin
        we        = 1'b0;
        waddr     = match_idx;
        wentry    = res.match;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        n_status  = STAT_OK;
        chosen    = 1'b0;
        add_val   = '0;
        sub_val   = '0;
        unique case (r_action)
            ACT_REGISTER: begin
                if (res.found) begin
                    add_val = r_item.count;
                end else if (!res.free_found) begin
                    n_status = STAT_TABLE_FULL;
                end else begin
                    we        = 1'b1;
                    waddr     = free_idx;
                    wentry    = r_item;
                    set_valid = 1'b1;
                    add_val   = r_item.count;
                end
            end
            ACT_USER_ADD: begin
                if (!res.found) begin
                    n_status = STAT_UNKNOWN;
                end else begin
                    we = 1'b1;
                    if (res.match.count != COUNT_MAX) begin
                        wentry.count = res.match.count + CountW'(1);
                    end
                    add_val = CountW'(1);
                end
            end
            ACT_USER_DEL: begin
                if (!res.found) begin
                    n_status = STAT_UNKNOWN;
                end else begin
                    we = 1'b1;
                    if (res.match.count != '0) begin
                        wentry.count = res.match.count - CountW'(1);
                    end
                    sub_val = CountW'(1);
                end
            end
            ACT_REMOVE: begin
                if (!res.found) begin
                    n_status = STAT_UNKNOWN;
                end else begin
                    clr_valid = 1'b1;
                    sub_val   = res.match.count;
                end
            end
            ACT_REQUEST: begin
                if (!res.any) begin
                    n_status = STAT_NO_SERVER;
                end else if (!res.best_found) begin
                    n_status = STAT_ALL_FULL;
                end else begin
                    chosen = 1'b1;
                end
            end
            default: ;
        endcase
        we = we && exec_fire;

        sum = {1'b0, r_total} + (TotalW+1)'(add_val);
        if (sum > {1'b0, TOTAL_MAX}) begin
            n_total = TOTAL_MAX;
        end else begin
            n_total = sum[TotalW-1:0];
        end
        if (TotalW'(sub_val) > r_total) begin
            n_total = '0;
        end else if (sub_val != '0) begin
            n_total = r_total - TotalW'(sub_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_fire) begin
                r_total <= n_total;
                if (set_valid) begin
                    r_valid[free_idx] <= 1'b1;
                end
                if (clr_valid) begin
                    r_valid[match_idx] <= 1'b0;
                end
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_status <= n_status;
            r_out_handle <= chosen ? res.best.handle  : '0;
            r_out_addr   <= chosen ? res.best.address : '0;
            r_out_port   <= chosen ? res.best.port    : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {r_total, r_out_port, r_out_addr, r_out_handle};

    `LCSS_ASSERT_SAME(a_no_server_empty, i_clk, i_rst_n,
        exec_fire && (n_status == STAT_NO_SERVER), r_valid == '0,
        "no server reported while table holds entries")
    `LCSS_ASSERT_SAME(a_table_full, i_clk, i_rst_n,
        exec_fire && (n_status == STAT_TABLE_FULL), &r_valid,
        "table full reported with a free slot")
    `LCSS_ASSERT_NEXT(a_remove_clears, i_clk, i_rst_n,
        exec_fire && clr_valid, !r_valid[$past(match_idx)],
        "removed server still valid")
    `LCSS_ASSERT_NEXT(a_del_no_rise, i_clk, i_rst_n,
        exec_fire && (r_action == ACT_USER_DEL), r_total <= $past(r_total),
        "online total rose on user removal")

endmodule
`default_nettype wire
